// ===== sv/hsva_pkg.sv =====
// ----------------------------------------------------------------------------
// hsva_pkg
// shared widths, register indexes, sector codes and fixed-point helpers
// ----------------------------------------------------------------------------
package hsva_pkg;

  localparam int PIX_W      = 8;   // one colour component
  localparam int FIX_W      = 16;  // hue, saturation, value
  localparam int NUM_W      = 11;  // sector numerator and 6 * delta
  localparam int DIV_STAGES = 4;   // register stages of the divider
  localparam int DIV_STEP   = FIX_W / DIV_STAGES;  // quotient bits per stage
  localparam int BACK_STAGES = 4;  // register stages of the back conversion
  localparam int PIPE_STAGES = 1 + DIV_STAGES + BACK_STAGES;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HUE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VAL = 2'd2;

  localparam logic [2:0] SECT_0 = 3'd0;
  localparam logic [2:0] SECT_1 = 3'd1;
  localparam logic [2:0] SECT_2 = 3'd2;
  localparam logic [2:0] SECT_3 = 3'd3;
  localparam logic [2:0] SECT_4 = 3'd4;

  localparam logic [FIX_W-1:0] ONE16 = 16'hFFFF;

  // floor(x / 65535): x = a * 65536 + b gives remainder a + b below 3 * 65535
  function automatic logic [FIX_W-1:0] div_one16(input logic [2*FIX_W-1:0] x);
    logic [FIX_W:0] s;
    logic [FIX_W:0] q;
    s = {1'b0, x[2*FIX_W-1:FIX_W]} + {1'b0, x[FIX_W-1:0]};
    q = {1'b0, x[2*FIX_W-1:FIX_W]};
    if (s >= 17'd65535) q = q + 17'd1;
    if (s >= 17'd131070) q = q + 17'd1;
    return q[FIX_W-1:0];
  endfunction

  // floor(x / 257): x = a * 257 + (b - a), one borrow when b < a
  function automatic logic [PIX_W-1:0] to_byte(input logic [FIX_W-1:0] x);
    logic [PIX_W-1:0] a;
    a = x[FIX_W-1:PIX_W];
    if (x[PIX_W-1:0] < a) a = a - 8'd1;
    return a;
  endfunction

endpackage

// ===== sv/hsva_if.sv =====
// ----------------------------------------------------------------------------
// hsva pixel channels
// valid/ready channels for input and adjusted pixels
// ----------------------------------------------------------------------------
interface hsva_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  modport source (output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface hsva_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  modport source (output valid, output red_out, output green_out, output blue_out,
                  input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out, output ready);
endinterface

// ===== sv/hsv_adjust_pixel.sv =====
// ----------------------------------------------------------------------------
// hsv_adjust_pixel
// rgb to hsv, hue/saturation/value offsets, hsv back to rgb
// ----------------------------------------------------------------------------
// One 8-bit rgb pixel in, one adjusted rgb pixel out, in the same order. The
// block is a nine-stage pipeline: stage one finds max, min and the hue sector
// numerator, stages two to five hold two restoring dividers (saturation and
// hue, four quotient bits per stage), and stages six to nine add the offsets
// and run the hexcone back conversion, the last stage being the output
// register. A pixel can enter every clock while the output is not stalled,
// so throughput is one pixel per cycle. Each stage holds its item only while
// the stage after it is full and stalled, so empty slots are filled even
// while the output waits. Hue offset wraps around the turn, saturation and
// value offsets clip at one. Offsets are written through the cfg port and
// should only change while the pipeline is empty.
// ----------------------------------------------------------------------------
module hsv_adjust_pixel (
  input  logic                              clk,
  input  logic                              rst,
  hsva_in_if.sink                           pix_in,
  hsva_out_if.source                        pix_out,
  input  logic                              cfg_write,
  input  logic [hsva_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hsva_pkg::FIX_W-1:0]        cfg_data
);
  import hsva_pkg::*;

  // offset registers
  logic [FIX_W-1:0] hue_offset, saturation_offset, value_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_offset        <= '0;
      saturation_offset <= '0;
      value_offset      <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_HUE: hue_offset        <= cfg_data;
        CFG_SAT: saturation_offset <= cfg_data;
        CFG_VAL: value_offset      <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control: a stage loads when empty or when the next one moves
  logic [PIPE_STAGES-1:0] vld;
  logic [PIPE_STAGES-1:0] en;

  always_comb begin
    en[PIPE_STAGES-1] = !vld[PIPE_STAGES-1] || pix_out.ready;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= pix_in.valid;
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign pix_in.ready  = en[0];
  assign pix_out.valid = vld[PIPE_STAGES-1];

  // stage one: max, min, delta, sector numerator and divider operands
  logic [PIX_W-1:0] r, g, b, mx, mn, d;
  logic [NUM_W-1:0] d6, n;
  logic [23:0]      sat_num;  // delta * 65535

  assign r  = pix_in.red_in;
  assign g  = pix_in.green_in;
  assign b  = pix_in.blue_in;

  always_comb begin
    mx = (r > g) ? r : g;
    if (b > mx) mx = b;
    mn = (r < g) ? r : g;
    if (b < mn) mn = b;
    d  = mx - mn;
    d6 = {1'b0, d, 2'b00} + {2'b00, d, 1'b0};
    // red wins ties over green, green over blue
    if (r == mx) begin
      if (g >= b) n = {3'b000, g - b};
      else        n = d6 + {3'b000, g} - {3'b000, b};
    end else if (g == mx) begin
      n = {2'b00, d, 1'b0} + {3'b000, b} - {3'b000, r};
    end else begin
      n = {1'b0, d, 2'b00} + {3'b000, r} - {3'b000, g};
    end
    sat_num = {d, 16'h0000} - {16'h0000, d};
  end

  logic [NUM_W-1:0] s1_sat_hi, s1_sat_den, s1_hue_hi, s1_hue_den;
  logic [FIX_W-1:0] s1_sat_lo;
  logic [FIX_W-1:0] s1_val;
  logic             s1_grey;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_sat_hi  <= {3'b000, sat_num[23:16]};
      s1_sat_lo  <= sat_num[15:0];
      s1_sat_den <= {3'b000, mx};
      s1_hue_hi  <= n;
      s1_hue_den <= d6;
      s1_val     <= {mx, mx};  // mx * 257
      s1_grey    <= (d == '0);
    end
  end

  // stages two to five: dividers, value and grey flag ride alongside
  logic [FIX_W-1:0] sat_q, hue_q;

  hsva_div u_div_sat (
    .clk    (clk),
    .en     (en[DIV_STAGES:1]),
    .num_hi (s1_sat_hi),
    .num_lo (s1_sat_lo),
    .den    (s1_sat_den),
    .quot   (sat_q)
  );

  hsva_div u_div_hue (
    .clk    (clk),
    .en     (en[DIV_STAGES:1]),
    .num_hi (s1_hue_hi),
    .num_lo ('0),
    .den    (s1_hue_den),
    .quot   (hue_q)
  );

  logic [FIX_W-1:0] val_d  [DIV_STAGES];
  logic             grey_d [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      val_d[0]  <= s1_val;
      grey_d[0] <= s1_grey;
    end
    for (int k = 1; k < DIV_STAGES; k++) begin
      if (en[k+1]) begin
        val_d[k]  <= val_d[k-1];
        grey_d[k] <= grey_d[k-1];
      end
    end
  end

  // grey input: saturation and hue both zero
  logic [FIX_W-1:0] sat, hue;
  assign sat = grey_d[DIV_STAGES-1] ? '0 : sat_q;
  assign hue = grey_d[DIV_STAGES-1] ? '0 : hue_q;

  // stages six to nine: offsets and back conversion
  hsva_back u_back (
    .clk               (clk),
    .en                (en[PIPE_STAGES-1:DIV_STAGES+1]),
    .hue               (hue),
    .sat               (sat),
    .val               (val_d[DIV_STAGES-1]),
    .hue_offset        (hue_offset),
    .saturation_offset (saturation_offset),
    .value_offset      (value_offset),
    .red               (pix_out.red_out),
    .green             (pix_out.green_out),
    .blue              (pix_out.blue_out)
  );

endmodule

// ===== sv/hsva_div.sv =====
// ----------------------------------------------------------------------------
// hsva_div
// pipelined restoring divider, 16-bit quotient, four quotient bits a stage
// ----------------------------------------------------------------------------
module hsva_div (
  input  logic                              clk,
  input  logic [hsva_pkg::DIV_STAGES-1:0]   en,
  input  logic [hsva_pkg::NUM_W-1:0]        num_hi,  // must be below den
  input  logic [hsva_pkg::FIX_W-1:0]        num_lo,
  input  logic [hsva_pkg::NUM_W-1:0]        den,
  output logic [hsva_pkg::FIX_W-1:0]        quot
);
  import hsva_pkg::*;

  logic [NUM_W-1:0] rem  [DIV_STAGES];
  logic [FIX_W-1:0] word [DIV_STAGES];  // numerator bits out, quotient bits in
  logic [NUM_W-1:0] dv   [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [NUM_W-1:0] rem_in;
    logic [FIX_W-1:0] word_in;
    logic [NUM_W-1:0] dv_in;
    logic [NUM_W-1:0] rem_next;
    logic [FIX_W-1:0] word_next;

    if (s == 0) begin : g_first
      assign rem_in  = num_hi;
      assign word_in = num_lo;
      assign dv_in   = den;
    end else begin : g_rest
      assign rem_in  = rem[s-1];
      assign word_in = word[s-1];
      assign dv_in   = dv[s-1];
    end

    always_comb begin
      logic [NUM_W:0] wide;
      rem_next  = rem_in;
      word_next = word_in;
      for (int j = 0; j < DIV_STEP; j++) begin
        wide      = {rem_next, word_next[FIX_W-1]};
        word_next = {word_next[FIX_W-2:0], 1'b0};
        if (wide >= {1'b0, dv_in}) begin
          wide         = wide - {1'b0, dv_in};
          word_next[0] = 1'b1;
        end
        rem_next = wide[NUM_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem[s]  <= rem_next;
        word[s] <= word_next;
        dv[s]   <= dv_in;
      end
    end
  end

  assign quot = word[DIV_STAGES-1];

endmodule

// ===== sv/hsva_back.sv =====
// ----------------------------------------------------------------------------
// hsva_back
// offset addition and hexcone back conversion to rgb, four register stages
// ----------------------------------------------------------------------------
module hsva_back (
  input  logic                               clk,
  input  logic [hsva_pkg::BACK_STAGES-1:0]   en,
  input  logic [hsva_pkg::FIX_W-1:0]         hue,
  input  logic [hsva_pkg::FIX_W-1:0]         sat,
  input  logic [hsva_pkg::FIX_W-1:0]         val,
  input  logic [hsva_pkg::FIX_W-1:0]         hue_offset,
  input  logic [hsva_pkg::FIX_W-1:0]         saturation_offset,
  input  logic [hsva_pkg::FIX_W-1:0]         value_offset,
  output logic [hsva_pkg::PIX_W-1:0]         red,
  output logic [hsva_pkg::PIX_W-1:0]         green,
  output logic [hsva_pkg::PIX_W-1:0]         blue
);
  import hsva_pkg::*;

  // stage a: offsets, sector and fraction
  logic [FIX_W-1:0] a_sv, a_vv, a_f;
  logic [2:0]       a_sect;
  logic             a_grey;
  // stage b: saturation times fraction
  logic [FIX_W-1:0] b_sv, b_vv, b_sf, b_st;
  logic [2:0]       b_sect;
  logic             b_grey;
  // stage c: value products
  logic [2*FIX_W-1:0] c_xp, c_xq, c_xt;
  logic [FIX_W-1:0]   c_vv;
  logic [2:0]         c_sect;
  logic               c_grey;

  logic [FIX_W-1:0]   hv;
  logic [FIX_W:0]     s_sum, v_sum;
  logic [FIX_W-1:0]   sv_next, vv_next;
  logic [FIX_W+2:0]   h6;
  logic [2*FIX_W-1:0] sf_full;
  logic [2*FIX_W:0]   st_full;
  logic [FIX_W-1:0]   p, q, t, ro, go, bo;

  assign hv      = hue + hue_offset;
  assign s_sum   = {1'b0, sat} + {1'b0, saturation_offset};
  assign v_sum   = {1'b0, val} + {1'b0, value_offset};
  assign sv_next = s_sum[FIX_W] ? ONE16 : s_sum[FIX_W-1:0];
  assign vv_next = v_sum[FIX_W] ? ONE16 : v_sum[FIX_W-1:0];
  assign h6      = {1'b0, hv, 2'b00} + {2'b00, hv, 1'b0};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_sv   <= sv_next;
      a_vv   <= vv_next;
      a_f    <= h6[FIX_W-1:0];
      a_sect <= h6[FIX_W+2:FIX_W];
      a_grey <= (sv_next == '0);
    end
  end

  assign sf_full = {16'h0000, a_sv} * {16'h0000, a_f};
  assign st_full = {17'h00000, a_sv} *
                   {16'h0000, {1'b1, {FIX_W{1'b0}}} - {1'b0, a_f}};

  always_ff @(posedge clk) begin
    if (en[1]) begin
      b_sv   <= a_sv;
      b_vv   <= a_vv;
      b_sf   <= sf_full[2*FIX_W-1:FIX_W];
      b_st   <= st_full[2*FIX_W-1:FIX_W];
      b_sect <= a_sect;
      b_grey <= a_grey;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      c_xp   <= {16'h0000, b_vv} * {16'h0000, ONE16 - b_sv};
      c_xq   <= {16'h0000, b_vv} * {16'h0000, ONE16 - b_sf};
      c_xt   <= {16'h0000, b_vv} * {16'h0000, ONE16 - b_st};
      c_vv   <= b_vv;
      c_sect <= b_sect;
      c_grey <= b_grey;
    end
  end

  assign p = div_one16(c_xp);
  assign q = div_one16(c_xq);
  assign t = div_one16(c_xt);

  always_comb begin
    if (c_grey) begin
      ro = c_vv; go = c_vv; bo = c_vv;
    end else begin
      case (c_sect)
        SECT_0:  begin ro = c_vv; go = t;    bo = p;    end
        SECT_1:  begin ro = q;    go = c_vv; bo = p;    end
        SECT_2:  begin ro = p;    go = c_vv; bo = t;    end
        SECT_3:  begin ro = p;    go = q;    bo = c_vv; end
        SECT_4:  begin ro = t;    go = p;    bo = c_vv; end
        default: begin ro = c_vv; go = p;    bo = q;    end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      red   <= to_byte(ro);
      green <= to_byte(go);
      blue  <= to_byte(bo);
    end
  end

endmodule

// ===== tb/tb_hsv_adjust_pixel.sv =====
// ----------------------------------------------------------------------------
// tb_hsv_adjust_pixel
// pixel-level check of the hsv adjust pipeline against a bit-exact predictor
// ----------------------------------------------------------------------------
// A table of directed pixels runs under several offset settings, then random
// pixels in bursts, with the output side stalling on its own pattern. Every
// accepted output pixel is compared with the oldest predicted pixel.
// ----------------------------------------------------------------------------
module tb_hsv_adjust_pixel;
  import hsva_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  // directed row: input pixel, and an expected pixel only where it is obvious
  typedef struct {
    pixel_t pix;
    bit     known;
    pixel_t want;
  } pix_row_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FIX_W-1:0] cfg_data;

  hsva_in_if  pix_in ();
  hsva_out_if pix_out ();

  hsv_adjust_pixel dut (
    .clk(clk), .rst(rst), .pix_in(pix_in), .pix_out(pix_out),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // offsets as the predictor sees them
  logic [15:0] hue_shift;
  logic [15:0] sat_shift;
  logic [15:0] val_shift;

  pixel_t adjusted_q[$];
  int     fails;
  int     cycles;
  bit     stall_on;   // receiver stalls only while set

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // cycle limit, generous against about 650 pixels through the pipeline
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 200000) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // fixed-point hsv adjust of one pixel
  function automatic pixel_t hsv_adjusted(pixel_t px);
    logic [31:0] r, g, b, mx, mn, d, n, hue, sat, val;
    logic [63:0] hv, sv, vv, h6, f, p, q, t, ro, go, bo;
    pixel_t res;
    r = px.r; g = px.g; b = px.b;
    mx = (r > g) ? r : g;
    if (b > mx) mx = b;
    mn = (r < g) ? r : g;
    if (b < mn) mn = b;
    d = mx - mn;
    val = mx * 257;
    sat = (mx != 0) ? (d * 65535) / mx : 0;
    hue = 0;
    if (sat != 0) begin
      if (r == mx) n = (g >= b) ? (g - b) : (6 * d + g - b);
      else if (g == mx) n = 2 * d + b - r;
      else n = 4 * d + r - g;
      hue = (64'(n) * 65536) / (6 * 64'(d));
    end
    hv = (hue + hue_shift) & 32'hFFFF;
    sv = sat + sat_shift;
    if (sv > 65535) sv = 65535;
    vv = val + val_shift;
    if (vv > 65535) vv = 65535;
    if (sv == 0) begin
      ro = vv; go = vv; bo = vv;
    end else begin
      h6 = hv * 6;
      f = h6 & 64'hFFFF;
      p = vv * (65535 - sv) / 65535;
      q = vv * (65535 - (sv * f) / 65536) / 65535;
      t = vv * (65535 - (sv * (65536 - f)) / 65536) / 65535;
      case (h6 >> 16)
        SECT_0: begin ro = vv; go = t; bo = p; end
        SECT_1: begin ro = q; go = vv; bo = p; end
        SECT_2: begin ro = p; go = vv; bo = t; end
        SECT_3: begin ro = p; go = q; bo = vv; end
        SECT_4: begin ro = t; go = p; bo = vv; end
        default: begin ro = vv; go = p; bo = q; end
      endcase
    end
    res.r = 8'(ro / 257);
    res.g = 8'(go / 257);
    res.b = 8'(bo / 257);
    return res;
  endfunction

  // output side: stall pattern driven at the falling edge, checks at the rising
  initial begin
    pix_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!stall_on) pix_out.ready <= 1'b1;
      else pix_out.ready <= ((cycles % 11) < 7) && ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    pixel_t got, exp_px;
    if (!rst && pix_out.valid && pix_out.ready) begin
      got = '{pix_out.red_out, pix_out.green_out, pix_out.blue_out};
      if (adjusted_q.size() == 0) begin
        $error("output pixel %h with nothing predicted", got);
        fails++;
      end else begin
        exp_px = adjusted_q.pop_front();
        if (got.r !== exp_px.r) begin
          $error("red_out: expected %0d, got %0d", exp_px.r, got.r); fails++;
        end
        if (got.g !== exp_px.g) begin
          $error("green_out: expected %0d, got %0d", exp_px.g, got.g); fails++;
        end
        if (got.b !== exp_px.b) begin
          $error("blue_out: expected %0d, got %0d", exp_px.b, got.b); fails++;
        end
      end
    end
  end

  // register write while the pipeline is empty; mirror updated alongside
  task automatic write_offset(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_HUE: hue_shift = data;
      CFG_SAT: sat_shift = data;
      CFG_VAL: val_shift = data;
      default: ;
    endcase
  endtask

  task automatic set_offsets(logic [15:0] h, logic [15:0] s, logic [15:0] v);
    write_offset(CFG_HUE, h);
    write_offset(CFG_SAT, s);
    write_offset(CFG_VAL, v);
  endtask

  // one pixel through the valid/ready handshake, prediction queued on accept
  task automatic send_pixel(pixel_t px, bit known, pixel_t want);
    @(negedge clk);
    pix_in.valid    <= 1'b1;
    pix_in.red_in   <= px.r;
    pix_in.green_in <= px.g;
    pix_in.blue_in  <= px.b;
    do @(posedge clk); while (!pix_in.ready);
    adjusted_q.push_back(known ? want : hsv_adjusted(px));
  endtask

  task automatic drop_valid();
    @(negedge clk);
    pix_in.valid <= 1'b0;
  endtask

  // wait for the pipeline to drain, then idle with nothing in flight
  task automatic drain();
    while (adjusted_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  pix_row_t directed[$];

  task automatic add_row(pixel_t px, bit known, pixel_t want);
    pix_row_t row;
    row.pix = px; row.known = known; row.want = want;
    directed.push_back(row);
  endtask

  task automatic run_directed();
    foreach (directed[i]) send_pixel(directed[i].pix, directed[i].known, directed[i].want);
    drop_valid();
    drain();
  endtask

  // mostly uniform pixels, some greys, near-greys and saturated corners
  function automatic pixel_t random_pixel();
    pixel_t px;
    int m;
    px = 24'($urandom);
    m = $urandom_range(0, 9);
    if (m == 0) begin
      px.g = px.r; px.b = px.r;
    end else if (m == 1) begin
      px.g = px.r + 8'($urandom_range(0, 2)); px.b = px.r;
    end else if (m == 2) begin
      px.r = {8{px.r[0]}}; px.g = {8{px.g[0]}}; px.b = {8{px.b[0]}};
    end
    return px;
  endfunction

  task automatic run_random(int count);
    int burst;
    int left;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      for (int k = 0; k < burst; k++) send_pixel(random_pixel(), 1'b0, '0);
      left -= burst;
      if ($urandom_range(0, 2) != 0) begin
        drop_valid();
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end
    end
    drop_valid();
    drain();
  endtask

  initial begin
    fails = 0;
    stall_on = 1'b0;
    hue_shift = '0; sat_shift = '0; val_shift = '0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_HUE;
    cfg_data = '0;
    pix_in.valid = 1'b0;
    pix_in.red_in = '0;
    pix_in.green_in = '0;
    pix_in.blue_in = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table after reset: primaries and greys read straight off
    add_row('{8'd0,   8'd0,   8'd0},   1, '{8'd0,   8'd0,   8'd0});
    add_row('{8'd255, 8'd255, 8'd255}, 1, '{8'd255, 8'd255, 8'd255});
    add_row('{8'd128, 8'd128, 8'd128}, 1, '{8'd128, 8'd128, 8'd128});
    add_row('{8'd255, 8'd0,   8'd0},   1, '{8'd255, 8'd0,   8'd0});
    add_row('{8'd0,   8'd255, 8'd0},   1, '{8'd0,   8'd255, 8'd0});
    add_row('{8'd0,   8'd0,   8'd255}, 1, '{8'd0,   8'd0,   8'd255});
    // red max with blue above green wraps the numerator
    add_row('{8'd200, 8'd10,  8'd90},  0, '0);
    // ties for the maximum
    add_row('{8'd200, 8'd200, 8'd50},  0, '0);
    add_row('{8'd30,  8'd220, 8'd220}, 0, '0);
    add_row('{8'd180, 8'd40,  8'd180}, 0, '0);
    // one step off grey, and each sector
    add_row('{8'd1,   8'd0,   8'd0},   0, '0);
    add_row('{8'd255, 8'd254, 8'd255}, 0, '0);
    add_row('{8'd250, 8'd120, 8'd10},  0, '0);
    add_row('{8'd120, 8'd250, 8'd10},  0, '0);
    add_row('{8'd10,  8'd250, 8'd120}, 0, '0);
    add_row('{8'd10,  8'd120, 8'd250}, 0, '0);
    add_row('{8'd120, 8'd10,  8'd250}, 0, '0);
    add_row('{8'd250, 8'd10,  8'd120}, 0, '0);
    add_row('{8'hAA,  8'h55,  8'hAA},  0, '0);
    add_row('{8'h55,  8'hAA,  8'h55},  0, '0);
    run_directed();

    // same table, predictor checked, under offset extremes
    foreach (directed[i]) directed[i].known = 1'b0;
    set_offsets(16'hFFFF, 16'hFFFF, 16'hFFFF);  // full saturation and value clip
    run_directed();
    set_offsets(16'h8000, 16'h0000, 16'h0000);  // half turn of hue
    run_directed();
    set_offsets(16'h2AAB, 16'h4000, 16'h0101);
    run_directed();

    // random part: six settings, receiver stalls in all but the first and fourth
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) set_offsets(16'h0000, 16'h0000, 16'h0000);
      else if (ph == 1) set_offsets(16'hFFFF, 16'h0000, 16'hFFFF);
      else set_offsets(16'($urandom), 16'($urandom_range(0, 3) == 0 ? $urandom : 0),
                       16'($urandom_range(0, 1) == 0 ? $urandom_range(0, 4096) : $urandom));
      stall_on = (ph % 3) != 0;
      run_random(95);
    end

    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/hsva_pkg.sv
sv/hsva_if.sv
sv/hsva_div.sv
sv/hsva_back.sv
sv/hsv_adjust_pixel.sv
tb/tb_hsv_adjust_pixel.sv
